FILE: rtl/core/hex_color_tag_text_parser_macros.svh
// Assertion macros for the color tag text parser.
// Included by the top level; needs nothing else.
`ifndef HEX_COLOR_TAG_TEXT_PARSER_MACROS_SVH
`define HEX_COLOR_TAG_TEXT_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HCTP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HCTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/hctp_pkg.sv
// Shared types, character codes and hex helpers for the color tag text parser.
// No dependencies.
`default_nettype none

package hctp_pkg;

   localparam int TagStore = 5;
   localparam int RunBytes = TagStore + 1;
   localparam int CountBits = 3;

   localparam logic [7:0] CharHash       = 8'h23;
   localparam logic [7:0] CharUnderscore = 8'h5F;
   localparam logic [7:0] CharNewline    = 8'h0A;
   localparam logic [7:0] CharSpace      = 8'h20;

   localparam logic [31:0] DefaultColorReset = 32'hFFFF_FFFF;
   localparam logic [7:0]  FullAlpha         = 8'hFF;

   typedef enum logic [1:0] {
      KindChar = 2'd0,
      KindLine = 2'd1,
      KindEnd  = 2'd2
   } kind_type;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         n = 4'(c - 8'h30);
      end else if (c inside {[8'h61:8'h66]}) begin
         n = 4'(c - 8'h61 + 8'd10);
      end else if (c inside {[8'h41:8'h46]}) begin
         n = 4'(c - 8'h41 + 8'd10);
      end
      return n;
   endfunction

   function automatic logic [7:0] byte_of(input logic [7:0] hi, input logic [7:0] lo);
      return {nibble_of(hi), nibble_of(lo)};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hex_color_tag_text_parser.sv
// Color tag text parser: bytes in, colored glyph / line end / end of text out.
// A req byte passes the input register, then the result run register, to rsp.
// Throughput: one byte per cycle unless rsp stalls; an end-of-text byte gives 1 to 7
// results, one per cycle unless rsp stalls, through the single result register.
// Reset (synchronous, high): tag state cleared, default and current color all ones.
// Depends on hctp_pkg and hex_color_tag_text_parser_macros.svh.
`default_nettype none
`include "hex_color_tag_text_parser_macros.svh"

module hex_color_tag_text_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [31:0]        csr_default_color,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [7:0]         req_char_code,
   input  wire logic               req_end_of_text,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      hctp_pkg::kind_type rsp_kind,
   output      logic [7:0]         rsp_glyph,
   output      logic [31:0]        rsp_color,
   output      logic               rsp_last_of_run
);
   import hctp_pkg::*;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // parser state
   logic                 tag_open_ff, tag_open_in;
   logic [CountBits-1:0] tag_cnt_ff, tag_cnt_in;
   logic [7:0]           tag_chars_ff [TagStore];
   logic [7:0]           tag_chars_in [TagStore];
   logic [31:0]          cur_color_ff, cur_color_in;
   logic [31:0]          default_color_ff;

   // result run register
   logic                 run_valid_ff;
   logic [7:0]           run_bytes_ff [RunBytes];
   logic [CountBits-1:0] run_left_ff;
   logic                 run_end_ff;
   logic [31:0]          run_color_ff;

   // load values for the run register
   logic [7:0]           ld_bytes [RunBytes];
   logic [CountBits-1:0] ld_left;
   logic                 ld_end;

   logic [7:0]  tag_r, tag_g, tag_b;
   logic [31:0] tag_color;
   logic        zero_res, run_free, proc_fire, run_load, out_last, rsp_fire, csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign tag_r = byte_of(tag_chars_ff[0], tag_chars_ff[1]);
   assign tag_g = byte_of(tag_chars_ff[2], tag_chars_ff[3]);
   assign tag_b = byte_of(tag_chars_ff[4], in_char_ff);
   assign tag_color = (tag_r == 8'd0 && tag_g == 8'd0 && tag_b == 8'd0) ?
                      default_color_ff : {FullAlpha, tag_b, tag_g, tag_r};

   always_comb begin
      tag_open_in  = tag_open_ff;
      tag_cnt_in   = tag_cnt_ff;
      tag_chars_in = tag_chars_ff;
      cur_color_in = cur_color_ff;
      for (int k = 0; k < RunBytes; k++) begin
         ld_bytes[k] = 8'd0;
      end
      ld_left = '0;
      ld_end  = in_last_ff;
      if (tag_open_ff) begin
         if (tag_cnt_ff >= CountBits'(TagStore)) begin
            cur_color_in = tag_color;
            tag_open_in  = 1'b0;
            tag_cnt_in   = '0;
         end else begin
            tag_chars_in[tag_cnt_ff] = in_char_ff;
            tag_cnt_in = tag_cnt_ff + 1'b1;
            if (in_last_ff) begin
               // text ended inside a tag: replay '#' and the collected bytes
               ld_bytes[0] = CharHash;
               for (int k = 0; k < TagStore; k++) begin
                  ld_bytes[k+1] = tag_chars_in[k];
               end
               ld_left = tag_cnt_ff + CountBits'(2);
            end
         end
      end else if (in_char_ff == CharHash && !in_last_ff) begin
         tag_open_in = 1'b1;
         tag_cnt_in  = '0;
      end else begin
         ld_bytes[0] = in_char_ff;
         ld_left     = CountBits'(1);
         if (in_char_ff == CharNewline) begin
            cur_color_in = default_color_ff;
         end
      end
      if (in_last_ff) begin
         tag_open_in  = 1'b0;
         tag_cnt_in   = '0;
         cur_color_in = default_color_ff;
      end
   end

   assign out_last  = (run_left_ff == CountBits'(1) && !run_end_ff) || (run_left_ff == '0);
   assign zero_res  = (ld_left == '0) && !ld_end;
   assign run_free  = !run_valid_ff || (rsp_fire && out_last);
   assign proc_fire = in_valid_ff && (zero_res || run_free);
   assign run_load  = proc_fire && !zero_res;
   assign req_ready = !in_valid_ff || proc_fire;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         tag_open_ff      <= 1'b0;
         tag_cnt_ff       <= '0;
         cur_color_ff     <= DefaultColorReset;
         default_color_ff <= DefaultColorReset;
         run_valid_ff     <= 1'b0;
         run_left_ff      <= '0;
         run_end_ff       <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (proc_fire) begin
            in_valid_ff <= 1'b0;
         end
         if (csr_fire) begin
            default_color_ff <= csr_default_color;
            cur_color_ff     <= csr_default_color;
         end else if (proc_fire) begin
            cur_color_ff <= cur_color_in;
         end
         if (proc_fire) begin
            tag_open_ff <= tag_open_in;
            tag_cnt_ff  <= tag_cnt_in;
         end
         if (run_load) begin
            run_valid_ff <= 1'b1;
            run_left_ff  <= ld_left;
            run_end_ff   <= ld_end;
         end else if (rsp_fire) begin
            if (out_last) begin
               run_valid_ff <= 1'b0;
            end else if (run_left_ff != '0) begin
               run_left_ff <= run_left_ff - 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_end_of_text;
      end
      if (proc_fire) begin
         tag_chars_ff <= tag_chars_in;
      end
      if (run_load) begin
         run_bytes_ff <= ld_bytes;
         run_color_ff <= cur_color_ff;
      end else if (rsp_fire && run_left_ff != '0) begin
         for (int k = 0; k < RunBytes - 1; k++) begin
            run_bytes_ff[k] <= run_bytes_ff[k+1];
         end
         run_bytes_ff[RunBytes-1] <= 8'd0;
         if (run_bytes_ff[0] == CharNewline) begin
            run_color_ff <= default_color_ff;
         end
      end
   end

   always_comb begin
      rsp_kind  = KindEnd;
      rsp_glyph = 8'd0;
      rsp_color = 32'd0;
      if (run_left_ff != '0) begin
         if (run_bytes_ff[0] == CharNewline) begin
            rsp_kind = KindLine;
         end else begin
            rsp_kind  = KindChar;
            rsp_glyph = (run_bytes_ff[0] == CharUnderscore) ? CharSpace : run_bytes_ff[0];
            rsp_color = run_color_ff;
         end
      end
   end

   assign rsp_valid       = run_valid_ff;
   assign rsp_last_of_run = out_last;

   `HCTP_ASSERT_SAME(a_run_nonempty, clock, reset, run_valid_ff && run_left_ff == '0,
      run_end_ff, "result run holds neither bytes nor end of text")
   `HCTP_ASSERT_SAME(a_run_bound, clock, reset, run_valid_ff,
      run_left_ff <= CountBits'(RunBytes), "result run longer than the byte store")
   `HCTP_ASSERT_SAME(a_tag_count_idle, clock, reset, !tag_open_ff,
      tag_cnt_ff == '0, "tag count nonzero with no tag open")
   `HCTP_ASSERT_NEXT(a_end_restores, clock, reset, proc_fire && in_last_ff,
      !tag_open_ff && cur_color_ff == default_color_ff,
      "end of text did not restore parser state")

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for hex_color_tag_text_parser: text bytes in, colored glyphs out.
// Predicts every result from its own model of the tag parser and default color register.
// Depends on hctp_pkg and the hex_color_tag_text_parser RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hctp_pkg::*;

   localparam int SettleCycles = 10;
   localparam int LongHold = 80;
   localparam int QuietLimit = 1000;
   localparam int MaxReports = 40;
   localparam logic [7:0] DigitZero = "0";
   localparam logic [7:0] NotHex = "g";

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  glyph;
      logic [31:0] color;
      logic        last;
   } glyph_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_default_color = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = '0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   kind_type    rsp_kind;
   logic [7:0]  rsp_glyph;
   logic [31:0] rsp_color;
   logic        rsp_last_of_run;

   // parser model state
   logic [31:0] dflt_color = DefaultColorReset;
   logic [31:0] cur_color = DefaultColorReset;
   logic        tag_active = 1'b0;
   int          tag_len = 0;
   logic [7:0]  tag_bytes [TagStore];

   glyph_result_type run_q[$];
   glyph_result_type glyphs_due[$];
   logic [7:0]       text_bytes[$];

   logic idle_enable = 1'b1;
   logic hold_rsp = 1'b0;
   int   errors = 0;
   int   quiet_cycles = 0;
   int   bytes_sent = 0;
   int   texts_done = 0;
   int   results_seen = 0;
   int   tags_applied = 0;
   int   tags_cut = 0;
   int   csr_writes = 0;

   hex_color_tag_text_parser uut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_default_color(csr_default_color),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_glyph       (rsp_glyph),
      .rsp_color       (rsp_color),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      return 4'd0;
   endfunction

   function void queue_result(input glyph_result_type r);
      run_q.insert(run_q.size(), r);
   endfunction

   function void queue_text(input logic [7:0] b);
      text_bytes.insert(text_bytes.size(), b);
   endfunction

   function void emit_plain(input logic [7:0] c);
      if (c == CharNewline) begin
         queue_result('{KindLine, 8'h00, 32'h0, 1'b0});
         cur_color = dflt_color;
      end else begin
         queue_result('{KindChar, (c == CharUnderscore) ? CharSpace : c, cur_color, 1'b0});
      end
   endfunction

   function void parse_byte(input logic [7:0] c, input logic eot);
      logic [7:0] r, g, b;
      int         i;
      run_q.delete();
      if (tag_active) begin
         if (tag_len == TagStore) begin
            r = {hex_value(tag_bytes[0]), hex_value(tag_bytes[1])};
            g = {hex_value(tag_bytes[2]), hex_value(tag_bytes[3])};
            b = {hex_value(tag_bytes[4]), hex_value(c)};
            cur_color = ((r | g | b) == 8'h00) ? dflt_color : {FullAlpha, b, g, r};
            tag_active = 1'b0;
            tag_len = 0;
            tags_applied++;
         end else begin
            tag_bytes[tag_len] = c;
            tag_len++;
            if (eot) begin
               // text ended mid-tag: replay as plain text
               queue_result('{KindChar, CharHash, cur_color, 1'b0});
               for (i = 0; i < tag_len; i++) emit_plain(tag_bytes[i]);
               tags_cut++;
            end
         end
      end else if (c == CharHash && !eot) begin
         tag_active = 1'b1;
         tag_len = 0;
      end else begin
         emit_plain(c);
      end
      if (eot) begin
         queue_result('{KindEnd, 8'h00, 32'h0, 1'b0});
         tag_active = 1'b0;
         tag_len = 0;
         cur_color = dflt_color;
         texts_done++;
      end
      if (run_q.size() != 0) run_q[run_q.size() - 1].last = 1'b1;
      for (i = 0; i < run_q.size(); i++) glyphs_due.insert(glyphs_due.size(), run_q[i]);
   endfunction

   function void report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      errors++;
      if (errors <= MaxReports)
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endfunction

   // result checker
   always @(posedge clock) begin
      glyph_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (glyphs_due.size() == 0) begin
            errors++;
            if (errors <= MaxReports)
               $display("%0t ns: unexpected result, expected none, actual kind %0d glyph %h color %h",
                        $time, rsp_kind, rsp_glyph, rsp_color);
         end else begin
            want = glyphs_due.pop_front();
            if (rsp_kind !== want.kind) report_field("kind", 32'(want.kind), 32'(rsp_kind));
            if (rsp_glyph !== want.glyph) report_field("glyph", 32'(want.glyph), 32'(rsp_glyph));
            if (rsp_color !== want.color) report_field("color", want.color, rsp_color);
            if (rsp_last_of_run !== want.last)
               report_field("last_of_run", 32'(want.last), 32'(rsp_last_of_run));
         end
      end
   end

   // result side: random stalls, plus one long hold on request
   initial begin : rsp_side
      int n;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (LongHold - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready = 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, glyphs_due.size());
            $display("hex_color_tag_text_parser regression: fail");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] c, input logic eot);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_char_code = c;
      req_end_of_text = eot;
      do @(posedge clock); while (!req_ready);
      parse_byte(c, eot);
      bytes_sent++;
   endtask

   task automatic send_string(input string s, input logic eot_on_last);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i], eot_on_last && i == s.len() - 1);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (glyphs_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_default_color(input logic [31:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_default_color = value;
      do @(posedge clock); while (!csr_ready);
      dflt_color = value;
      cur_color = value;
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [7:0] tag_char();
      case ($urandom_range(0, 3))
         0: return 8'("0" + $urandom_range(0, 9));
         1: return 8'("a" + $urandom_range(0, 5));
         2: return 8'("A" + $urandom_range(0, 5));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly well-formed tags and text, cut to length so some end mid-tag
   task automatic build_text(input int len);
      logic zero_tag;
      text_bytes.delete();
      while (text_bytes.size() < len) begin
         case ($urandom_range(0, 7))
            0, 1: begin
               queue_text(CharHash);
               zero_tag = ($urandom_range(0, 4) == 0);
               repeat (6) begin
                  if (!zero_tag) queue_text(tag_char());
                  else case ($urandom_range(0, 2))
                     0: queue_text(DigitZero);
                     1: queue_text(NotHex);
                     default: queue_text(CharNewline);
                  endcase
               end
            end
            2: queue_text(CharUnderscore);
            3: queue_text(CharNewline);
            default: queue_text(8'($urandom_range(0, 255)));
         endcase
      end
      while (text_bytes.size() > len) void'(text_bytes.pop_back());
   endtask

   task automatic send_random_texts(input int count);
      int left, len, i;
      left = count;
      while (left > 0) begin
         len = $urandom_range(1, 14);
         if (len > left) len = left;
         build_text(len);
         for (i = 0; i < len; i++) send_byte(text_bytes[i], i == len - 1);
         left -= len;
      end
   endtask

   task automatic t_plain_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(CharUnderscore, 1'b0);
      send_byte(CharNewline, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic t_color_tags();
      send_string("#1a2B3c", 1'b0);
      // cut short after five tag bytes: longest run of results
      send_string("#a_\nd9", 1'b1);
      // all-zero tag with newline inside, completing on the last byte
      send_string("#0\n0g_0", 1'b1);
      send_string("#", 1'b1);
   endtask

   task automatic t_color_register();
      write_default_color(32'h0000_0000);
      send_random_texts(28);
      write_default_color($urandom);
      send_random_texts(28);
      write_default_color(32'hFFFF_FFFF);
      send_random_texts(28);
      write_default_color($urandom);
      send_random_texts(28);
   endtask

   task automatic t_output_stall();
      int i;
      wait_idle();
      idle_enable = 1'b0;
      hold_rsp = 1'b1;
      for (i = 0; i < 24; i++) send_byte(8'("A" + i), i == 23);
      wait_idle();
      idle_enable = 1'b1;
   endtask

   task automatic t_steady_stream();
      wait_idle();
      idle_enable = 1'b0;
      send_random_texts(24);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      t_plain_bytes();
      t_color_tags();
      t_color_register();
      t_output_stall();
      t_steady_stream();
      wait_idle();
      $display("tb: %0d bytes in %0d texts, %0d results; %0d tags applied, %0d cut short",
               bytes_sent, texts_done, results_seen, tags_applied, tags_cut);
      $display("tb: %0d default color writes incl. all-zero and all-one, one %0d-cycle output hold",
               csr_writes, LongHold);
      if (errors == 0) begin
         $display("hex_color_tag_text_parser regression: pass");
      end else begin
         $display("hex_color_tag_text_parser regression: fail");
      end
      $finish;
   end

endmodule
